// ===== hdl/lpd_pkg.sv =====
// shared types and constants for the lidar packet deframer
// used by lpd_point_store and lidar_packet_deframer_top; no dependencies
`default_nettype none

package lpd_pkg;

  // packet framing
  localparam logic [7:0] PACKET_BYTES      = 8'd34;
  localparam logic [2:0] POINTS_PER_PACKET = 3'd4;
  localparam logic [7:0] SEQ_POS           = 8'd4;
  localparam logic [3:0] POINT_ROW_TAG     = 4'd1;   // byte positions 16 to 31

  // register reset values
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hE7;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h7E;
  localparam logic [7:0] ANGLE_BASE_RST  = 8'd160;

  // register map
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_ANGLE_BASE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC1 = 2'd1,
    PH_SYNC2 = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  // point status codes
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_WEAK    = 2'd2;

  // write of one point byte into the store
  typedef struct packed {
    logic       we;
    logic [1:0] row;
    logic [1:0] lane;
    logic [7:0] data;
  } pt_wr_t;

  // start of point emission for a finished packet
  typedef struct packed {
    logic       start;
    logic [6:0] code;
    logic       scan;
  } emit_start_t;

endpackage

`default_nettype wire

// ===== hdl/lpd_point_store.sv =====
// point byte memory (4 rows of 32 bits, byte lanes) and the point read-out sequencer
// depends on lpd_pkg
`default_nettype none

module lpd_point_store (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lpd_pkg::pt_wr_t      wr,
  input  wire lpd_pkg::emit_start_t emit,
  output logic                      busy,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_point_status,
  output logic [13:0]               out_distance_mm,
  output logic [15:0]               out_intensity,
  output logic [6:0]                out_angle_code,
  output logic [1:0]                out_point_index,
  output logic                      out_scan_start,
  output logic                      out_last_point
);

  logic [31:0] mem_r [4];

  logic [2:0]  remain_r, remain_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        inflight_r;
  logic [31:0] rd_data_r;
  logic [1:0]  rd_idx_r;
  logic [6:0]  code_r;
  logic        scan_r;
  logic        out_valid_r, out_valid_nxt;

  logic        issue;
  logic [7:0]  b0, b1, b2, b3;

  assign busy  = (remain_r != 3'd0);
  assign issue = busy && !inflight_r && (!out_valid_r || out_ready);

  // byte lane write, and a row read when a point is issued; no new row is read while the last one is in flight
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.row][8*wr.lane +: 8] <= wr.data;
    end
    if (issue) begin
      rd_data_r <= mem_r[idx_r];
      rd_idx_r  <= idx_r;
    end
    if (emit.start) begin
      code_r <= emit.code;
      scan_r <= emit.scan;
    end
  end

  always_comb begin
    remain_nxt = remain_r;
    idx_nxt    = idx_r;
    if (emit.start) begin
      remain_nxt = lpd_pkg::POINTS_PER_PACKET;
      idx_nxt    = 2'd0;
    end else if (issue) begin
      remain_nxt = remain_r - 3'd1;
      idx_nxt    = idx_r + 2'd1;
    end
    out_valid_nxt = out_valid_r;
    if (inflight_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r    <= 3'd0;
      idx_r       <= 2'd0;
      inflight_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      remain_r    <= remain_nxt;
      idx_r       <= idx_nxt;
      inflight_r  <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign b0 = rd_data_r[7:0];
  assign b1 = rd_data_r[15:8];
  assign b2 = rd_data_r[23:16];
  assign b3 = rd_data_r[31:24];

  // result register, loaded the cycle after the row read
  always_ff @(posedge clk) begin
    if (inflight_r) begin
      priority if (b1[7]) begin
        out_point_status <= lpd_pkg::ST_INVALID;
        out_distance_mm  <= 14'd0;
      end else if (b1[6]) begin
        out_point_status <= lpd_pkg::ST_WEAK;
        out_distance_mm  <= 14'd0;
      end else begin
        out_point_status <= lpd_pkg::ST_VALID;
        out_distance_mm  <= {b1[5:0], b0};
      end
      out_intensity   <= {b3, b2};
      out_angle_code  <= code_r;
      out_point_index <= rd_idx_r;
      out_scan_start  <= scan_r;
      out_last_point  <= ({1'b0, rd_idx_r} == (lpd_pkg::POINTS_PER_PACKET - 3'd1));
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hdl/lidar_packet_deframer_top.sv =====
// lidar packet deframer top level: byte framing, sequence capture and registers
// depends on lpd_pkg and lpd_point_store
`default_nettype none

// channel   direction  handshake          payload
// in_       input      in_valid/in_ready  in_rx_byte
// out_      output     out_valid/ready    status, distance, intensity, angle, index, flags
// cfg       apb write  psel/penable/...   sync_first, sync_second, angle_base at 0, 4, 8
//
// one byte is taken each cycle while in_ready is high; framing state updates in that cycle
// a packet that qualifies yields its points one at a time: a point memory row is read,
// then the result register loaded; no new row is read while one is in flight or out stalls
// a point byte of the next packet waits (in_ready low) while points are still read out
// rst_n is synchronous; no clearing pass, the point memory is written before it is read

module lidar_packet_deframer_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_point_status,
  output logic [13:0]                       out_distance_mm,
  output logic [15:0]                       out_intensity,
  output logic [6:0]                        out_angle_code,
  output logic [1:0]                        out_point_index,
  output logic                              out_scan_start,
  output logic                              out_last_point,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lpd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [lpd_pkg::PDATA_W-1:0]  pwdata,
  output logic [lpd_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  logic [7:0] sync_first_r, sync_second_r, angle_base_r;

  lpd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      count_r, count_nxt;
  logic [7:0]      exp_len_r, exp_len_nxt;
  logic [7:0]      seq_r;

  logic                 accept;
  logic                 busy;
  logic                 pt_pos;
  logic [7:0]           count_inc;
  logic [7:0]           seq_eff;
  logic [7:0]           diff;
  lpd_pkg::pt_wr_t      wr;
  lpd_pkg::emit_start_t emit;
  lpd_pkg::reg_idx_t    cfg_idx;
  logic                 cfg_wr;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = lpd_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= lpd_pkg::SYNC_FIRST_RST;
      sync_second_r <= lpd_pkg::SYNC_SECOND_RST;
      angle_base_r  <= lpd_pkg::ANGLE_BASE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lpd_pkg::REG_SYNC_FIRST:  sync_first_r  <= pwdata[7:0];
        lpd_pkg::REG_SYNC_SECOND: sync_second_r <= pwdata[7:0];
        lpd_pkg::REG_ANGLE_BASE:  angle_base_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lpd_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync_first_r};
      lpd_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second_r};
      lpd_pkg::REG_ANGLE_BASE:  prdata = {24'd0, angle_base_r};
      default:                  prdata = '0;
    endcase
  end

  // framing
  assign pt_pos    = (phase_r == lpd_pkg::PH_DATA) && (count_r[7:4] == lpd_pkg::POINT_ROW_TAG);
  assign in_ready  = !(pt_pos && busy);
  assign accept    = in_valid && in_ready;
  assign count_inc = count_r + 8'd1;
  assign seq_eff   = (count_r == lpd_pkg::SEQ_POS) ? in_rx_byte : seq_r;
  assign diff      = seq_eff - angle_base_r;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    exp_len_nxt = exp_len_r;
    wr.we       = 1'b0;
    wr.row      = count_r[3:2];
    wr.lane     = count_r[1:0];
    wr.data     = in_rx_byte;
    emit.start  = 1'b0;
    emit.code   = diff[7] ? 7'd127 : diff[6:0];
    emit.scan   = (diff == 8'd0);
    if (accept) begin
      unique case (phase_r)
        lpd_pkg::PH_HUNT: begin
          if (in_rx_byte == sync_first_r) begin
            phase_nxt = lpd_pkg::PH_SYNC1;
            count_nxt = 8'd1;
          end
        end
        lpd_pkg::PH_SYNC1: begin
          if (in_rx_byte == sync_second_r) begin
            phase_nxt = lpd_pkg::PH_SYNC2;
            count_nxt = count_inc;
          end else begin
            phase_nxt = lpd_pkg::PH_HUNT;
          end
        end
        lpd_pkg::PH_SYNC2: begin
          exp_len_nxt = in_rx_byte;
          phase_nxt   = lpd_pkg::PH_DATA;
          count_nxt   = count_inc;
        end
        lpd_pkg::PH_DATA: begin
          wr.we     = pt_pos;
          count_nxt = count_inc;
          if (count_inc >= exp_len_r) begin
            phase_nxt = lpd_pkg::PH_HUNT;
            // only a full-length packet with sequence at or above the base gives points
            emit.start = (count_inc == lpd_pkg::PACKET_BYTES) && (seq_eff >= angle_base_r);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lpd_pkg::PH_HUNT;
      count_r   <= 8'd0;
      exp_len_r <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      exp_len_r <= exp_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase_r == lpd_pkg::PH_DATA) && (count_r == lpd_pkg::SEQ_POS)) begin
      seq_r <= in_rx_byte;
    end
  end

  lpd_point_store u_store (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr               (wr),
    .emit             (emit),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_status (out_point_status),
    .out_distance_mm  (out_distance_mm),
    .out_intensity    (out_intensity),
    .out_angle_code   (out_angle_code),
    .out_point_index  (out_point_index),
    .out_scan_start   (out_scan_start),
    .out_last_point   (out_last_point)
  );

endmodule

`default_nettype wire
